/* rtl/vss_pkg.sv */
// Shared operation codes, status codes, field widths and control structs for the stack.
package vss_pkg;

    // Field widths of one input transaction and one result transaction
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int CNT5_W   = 5;
    localparam int IN_BITS  = OP_W + 2 * VAL_W;
    localparam int OUT_BITS = STAT_W + VAL_W + 2 * CNT5_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Largest value a 5-bit count field can show
    localparam logic [CNT5_W-1:0] CNT5_MAX = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // Write data select for the entry memory
    localparam logic [1:0] WR_KEY   = 2'd0;
    localparam logic [1:0] WR_NEW   = 2'd1;
    localparam logic [1:0] WR_RDATA = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;          // latch the accepted input transaction
        logic              rd_en;         // read entry memory
        logic              wr_en;         // write entry memory
        logic [1:0]        wr_sel;        // write data select
        logic              clr_match;     // clear match counter
        logic              inc_match;     // bump match counter
        logic              count_inc;     // push
        logic              count_dec;     // remove
        logic              emit;          // load result register
        logic [STAT_W-1:0] emit_status;
        logic              emit_entry;    // result carries read data
        logic              emit_matches;  // result carries match count
        logic              emit_last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;         // latched operation
        logic            match;      // read data equals key
        logic            match_any;  // match counter non-zero
        logic            out_free;   // result register can take a result
    } stat_t;

endpackage

/* rtl/vss_datapath.sv */
// Datapath: entry memory, entry count, item registers, comparator, match counter, result register.
module vss_datapath #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vss_pkg::cmd_t                    cmd,
    input  logic [AW-1:0]                    rd_addr,
    input  logic [AW-1:0]                    wr_addr,
    output vss_pkg::stat_t                   stat,
    output logic [CW-1:0]                    count,
    input  logic [vss_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vss_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import vss_pkg::*;

    logic [VAL_W-1:0]  mem [DEPTH];
    logic [VAL_W-1:0]  rd_data_reg;
    logic [VAL_W-1:0]  wr_data;
    logic [OP_W-1:0]   op_reg;
    logic [VAL_W-1:0]  key_reg;
    logic [VAL_W-1:0]  nv_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     match_reg, match_next;
    logic              valid_reg, valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [CNT5_W-1:0] mcnt_reg;
    logic [CNT5_W-1:0] depth_reg;
    logic              last_reg;
    logic [CNT5_W-1:0] mcnt_sat;
    logic [CNT5_W-1:0] depth_sat;
    logic              out_free;

    // Latched input transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= s_tdata[OP_W-1:0];
            key_reg <= s_tdata[OP_W +: VAL_W];
            nv_reg  <= s_tdata[OP_W+VAL_W +: VAL_W];
        end
    end

    // Write data select
    always_comb
    begin
        case (cmd.wr_sel)
            WR_KEY:   wr_data = key_reg;
            WR_NEW:   wr_data = nv_reg;
            WR_RDATA: wr_data = rd_data_reg;
            default:  wr_data = key_reg;
        endcase
    end

    // Entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entry count and match counter
    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        match_next = match_reg;
        if (cmd.clr_match)
        begin
            match_next = '0;
        end
        else if (cmd.inc_match)
        begin
            match_next = match_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            match_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            match_reg <= match_next;
        end
    end

    // Saturate counts to the 5-bit result fields
    assign mcnt_sat  = (32'(match_reg) > 32'(CNT5_MAX)) ? CNT5_MAX : CNT5_W'(match_reg);
    assign depth_sat = (32'(count_next) > 32'(CNT5_MAX)) ? CNT5_MAX : CNT5_W'(count_next);

    // Result register valid
    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            value_reg  <= cmd.emit_entry ? rd_data_reg : '0;
            mcnt_reg   <= cmd.emit_matches ? mcnt_sat : '0;
            depth_reg  <= depth_sat;
            last_reg   <= cmd.emit_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = OUT_TDATA_W'({depth_reg, mcnt_reg, value_reg, status_reg});

    assign count          = count_reg;
    assign stat.op        = op_reg;
    assign stat.match     = (rd_data_reg == key_reg);
    assign stat.match_any = (match_reg != '0);
    assign stat.out_free  = out_free;

endmodule

/* rtl/vss_ctrl.sv */
// Controller: sequences push, scan, remove-and-shift and list walks over the entry memory.
module vss_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  vss_pkg::stat_t stat,
    input  logic [CW-1:0]  count,
    output vss_pkg::cmd_t  cmd,
    output logic [AW-1:0]  rd_addr,
    output logic [AW-1:0]  wr_addr
);
    import vss_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FIND   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_LIST   = 3'd5;
    localparam logic [2:0] S_REPORT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_p2;
    logic [CW-1:0] top;
    logic          is_walk_op;

    assign idx_p1     = CW'(idx_reg) + CW'(1);
    assign idx_p2     = CW'(idx_reg) + CW'(2);
    assign top        = count - CW'(1);
    assign is_walk_op = stat.op inside {OP_SEARCH, OP_MODIFY, OP_REMOVE, OP_LIST};

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        cmd        = '0;
        cmd.wr_sel = WR_KEY;
        rd_addr    = idx_reg;
        wr_addr    = idx_reg;
        s_tready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load      = 1'b1;
                    cmd.clr_match = 1'b1;
                    state_next    = S_START;
                end
            end

            S_START:
            begin
                if (stat.op == OP_PUSH)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                        if (32'(count) >= DEPTH)
                        begin
                            cmd.emit_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.emit_status = ST_OK;
                            cmd.wr_en       = 1'b1;
                            cmd.wr_sel      = WR_KEY;
                            wr_addr         = AW'(count);
                            cmd.count_inc   = 1'b1;
                        end
                    end
                end
                else if (!is_walk_op || count == '0)
                begin
                    // unused op codes and walks over an empty stack give one result
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = is_walk_op ? ST_EMPTY : ST_OK;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.op == OP_SEARCH || stat.op == OP_MODIFY)
                begin
                    // bottom to top
                    cmd.rd_en  = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    // remove and list start from the top
                    cmd.rd_en  = 1'b1;
                    rd_addr    = AW'(top);
                    idx_next   = AW'(top);
                    found_next = 1'b0;
                    state_next = (stat.op == OP_REMOVE) ? S_FIND : S_LIST;
                end
            end

            S_SCAN:
            begin
                // compare entry idx, rewrite on modify, read idx+1 in parallel
                cmd.inc_match = stat.match;
                if (stat.op == OP_MODIFY && stat.match)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_NEW;
                    wr_addr    = idx_reg;
                end
                if (idx_p1 < count)
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = AW'(idx_p1);
                    idx_next  = AW'(idx_p1);
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_FIND:
            begin
                // topmost match search, walking down
                if (stat.match)
                begin
                    found_next = 1'b1;
                    state_next = S_SHIFT;
                    if (idx_p1 < count)
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = AW'(idx_p1);
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_reg - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                end
            end

            S_SHIFT:
            begin
                // close the gap: entry idx takes entry idx+1
                if (idx_p1 < count)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_RDATA;
                    wr_addr    = idx_reg;
                    idx_next   = AW'(idx_p1);
                    if (idx_p2 < count)
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = AW'(idx_p2);
                    end
                end
                else
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_REPORT;
                end
            end

            S_LIST:
            begin
                // one entry per free result slot, next read issued alongside
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_entry  = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_last   = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg - AW'(1);
                        idx_next  = idx_reg - AW'(1);
                    end
                end
            end

            S_REPORT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                    if (stat.op == OP_REMOVE)
                    begin
                        cmd.emit_status = found_reg ? ST_OK : ST_NOTFOUND;
                    end
                    else
                    begin
                        cmd.emit_matches = 1'b1;
                        cmd.emit_status  = stat.match_any ? ST_OK : ST_NOTFOUND;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

endmodule

/* rtl/value_search_stack.sv */
// Top level of the searchable value stack: controller plus datapath.
//
// A bounded LIFO of DEPTH signed 32-bit entries held in a single-port-read,
// single-port-write memory. One operation per input transaction. A push, an
// unused op or a walk over an empty stack gives a single result and reads no
// entry. Search and modify walk the entries bottom to top at one entry per
// cycle. Remove walks down to the topmost match and then shifts the entries
// above it down one per cycle. List reads the entries top to bottom and gives
// one result per cycle while the output is taken. The memory read port, one
// address per cycle, sets these rates. A new transaction is accepted once the
// previous one has placed its last result in the output register, even if
// that result has not yet been taken.
module value_search_stack #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // {op[2:0], key[34:3], new_value[66:35]}, zero padded
    input  logic [vss_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // {status[1:0], entry_value[33:2], match_count[38:34], depth_now[43:39]}, zero padded
    output logic [vss_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import vss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] count;

    vss_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .count    (count),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    vss_datapath #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .stat     (stat),
        .count    (count),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/vss_checker.sv */
// Port-level checker for the searchable value stack, bound to the top level.
module vss_checker #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [vss_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tlast
);
    import vss_pkg::*;

    localparam int DMAX = (DEPTH > 31) ? 31 : DEPTH;

    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_value;
    logic [CNT5_W-1:0] r_mcnt;
    logic [CNT5_W-1:0] r_depth;

    assign r_status = m_tdata[STAT_W-1:0];
    assign r_value  = m_tdata[STAT_W +: VAL_W];
    assign r_mcnt   = m_tdata[STAT_W+VAL_W +: CNT5_W];
    assign r_depth  = m_tdata[STAT_W+VAL_W+CNT5_W +: CNT5_W];

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reported depth never exceeds capacity
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(r_depth) <= DMAX)
        else $error("depth beyond capacity");

    // matches never exceed held entries
    a_mcnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> r_mcnt <= r_depth)
        else $error("match count above depth");

    // empty result: single, zero payload, zero depth
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r_status == ST_EMPTY |->
            m_tlast && r_value == '0 && r_mcnt == '0 && r_depth == '0)
        else $error("bad empty result");

    // full result only at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r_status == ST_FULL |-> m_tlast && 32'(r_depth) == DMAX)
        else $error("full reported below capacity");

endmodule

bind value_search_stack vss_checker #(.DEPTH(DEPTH)) u_vss_checker (.*);

/* dv/value_search_checker.sv */
`timescale 1ns / 100ps
// Checker for the value search stack: watches both channels, predicts and compares results.
module value_search_checker #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // {op[2:0], key[34:3], new_value[66:35]}, zero padded
    input  logic [vss_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // {status[1:0], entry_value[33:2], match_count[38:34], depth_now[43:39]}, zero padded
    input  logic [vss_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tlast,
    output int                               fail_count,
    output int                               pending,
    output int                               n_items,
    output int                               n_results
);
    import vss_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic [CNT5_W-1:0] hit_count;
        logic [CNT5_W-1:0] depth;
        logic              last;
    } stack_result_t;

    // Shadow copy of the stack
    logic [VAL_W-1:0] shadow_entries [DEPTH];
    int               shadow_depth;

    // Results still owed by the block, oldest first
    stack_result_t    owed_results [$];

    stack_result_t    want;
    stack_result_t    got;
    int               errs;

    function automatic logic [CNT5_W-1:0] clip5(int v);
        return (v > int'(CNT5_MAX)) ? CNT5_MAX : v[CNT5_W-1:0];
    endfunction

    // Queue one result; depth is taken after the operation has been applied
    function automatic void owe(logic [STAT_W-1:0] st, logic [VAL_W-1:0] val, int hits,
                                logic last);
        stack_result_t r;
        r.status    = st;
        r.value     = val;
        r.hit_count = clip5(hits);
        r.depth     = clip5(shadow_depth);
        r.last      = last;
        owed_results.push_back(r);
    endfunction

    // Apply one operation to the shadow stack and queue what it gives
    function automatic void stack_apply(logic [OP_W-1:0] op, logic [VAL_W-1:0] key,
                                        logic [VAL_W-1:0] nv);
        int hits;
        int pos;
        hits = 0;
        pos  = -1;
        if (op == OP_PUSH) begin
            if (shadow_depth >= DEPTH)
                owe(ST_FULL, '0, 0, 1'b1);
            else begin
                shadow_entries[shadow_depth] = key;
                shadow_depth++;
                owe(ST_OK, '0, 0, 1'b1);
            end
        end
        else if (op > OP_LIST)
            owe(ST_OK, '0, 0, 1'b1);
        else if (shadow_depth == 0)
            owe(ST_EMPTY, '0, 0, 1'b1);
        else begin
            case (op)
                OP_SEARCH, OP_MODIFY:
                begin
                    for (int i = 0; i < shadow_depth; i++) begin
                        if (shadow_entries[i] == key) begin
                            hits++;
                            if (op == OP_MODIFY)
                                shadow_entries[i] = nv;
                        end
                    end
                    owe(hits ? ST_OK : ST_NOTFOUND, '0, hits, 1'b1);
                end
                OP_REMOVE:
                begin
                    // topmost match goes, entries above it slide down
                    for (int i = shadow_depth - 1; i >= 0; i--)
                        if (pos < 0 && shadow_entries[i] == key)
                            pos = i;
                    if (pos >= 0) begin
                        for (int i = pos; i + 1 < shadow_depth; i++)
                            shadow_entries[i] = shadow_entries[i + 1];
                        shadow_depth--;
                    end
                    owe((pos >= 0) ? ST_OK : ST_NOTFOUND, '0, 0, 1'b1);
                end
                default:
                begin
                    // list, top to bottom
                    for (int i = shadow_depth - 1; i >= 0; i--)
                        owe(ST_OK, shadow_entries[i], 0, i == 0);
                end
            endcase
        end
    endfunction

    function automatic int field_diff(string what, logic signed [VAL_W-1:0] exp_v,
                                      logic signed [VAL_W-1:0] act_v);
        if (exp_v === act_v)
            return 0;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
        return 1;
    endfunction

    // Compare output transactions first, then predict from the input transaction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_depth = 0;
            owed_results.delete();
            fail_count   = 0;
            n_items      = 0;
            n_results    = 0;
            pending      = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                got.status    = m_tdata[STAT_W-1:0];
                got.value     = m_tdata[STAT_W +: VAL_W];
                got.hit_count = m_tdata[STAT_W + VAL_W +: CNT5_W];
                got.depth     = m_tdata[STAT_W + VAL_W + CNT5_W +: CNT5_W];
                got.last      = m_tlast;
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result, status %0d value %0d", $time,
                             got.status, $signed(got.value));
                    $display("%0t:   match_count %0d depth %0d last %0b", $time,
                             got.hit_count, got.depth, got.last);
                    fail_count++;
                end
                else begin
                    want = owed_results.pop_front();
                    errs = field_diff("status", VAL_W'(want.status), VAL_W'(got.status))
                         + field_diff("entry_value", want.value, got.value)
                         + field_diff("match_count", VAL_W'(want.hit_count),
                                      VAL_W'(got.hit_count))
                         + field_diff("depth_now", VAL_W'(want.depth), VAL_W'(got.depth))
                         + field_diff("last", VAL_W'(want.last), VAL_W'(got.last));
                    if (errs != 0)
                        fail_count++;
                end
            end
            if (s_tvalid && s_tready) begin
                n_items++;
                stack_apply(s_tdata[OP_W-1:0], s_tdata[OP_W +: VAL_W],
                            s_tdata[OP_W + VAL_W +: VAL_W]);
            end
            pending = owed_results.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the value search stack: stimulus, result sink, watchdog and verdict.
module tb_top;
    import vss_pkg::*;

    localparam int DEPTH        = 16;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE    = 8;

    // Op codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_NEG1 = 32'hffff_ffff;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic                    m_tready = 1'b0;
    wire                     s_tready;
    wire                     m_tvalid;
    wire [OUT_TDATA_W-1:0]   m_tdata;
    wire                     m_tlast;

    int               fail_count;
    int               pending;
    int               n_items;
    int               n_results;
    int               idle_cycles = 0;
    bit               no_idle     = 1'b0;
    logic [VAL_W-1:0] key_pool [POOL_SIZE];

    always #1 clk = ~clk;

    value_search_stack #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    value_search_checker #(.DEPTH(DEPTH)) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .n_items    (n_items),
        .n_results  (n_results)
    );

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    // Value from the key pool with a chance of hit_pct percent, so searches and removes can hit
    function automatic logic [VAL_W-1:0] pick_value(int hit_pct);
        if ($urandom_range(0, 99) < hit_pct)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // Drive one input transaction; entered and left at a falling edge
    task automatic send_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] key,
                             logic [VAL_W-1:0] nv);
        int gap;
        logic [IN_TDATA_W-1:0] word;
        gap  = draw_wait();
        word = '0;
        word[OP_W-1:0]          = op;
        word[OP_W +: VAL_W]     = key;
        word[OP_W + VAL_W +: VAL_W] = nv;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result sink with a random stall before each transaction
    initial begin : result_sink
        int stall;
        wait (rst_n);
        forever begin
            @(negedge clk);
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog: consecutive cycles without any transaction
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int roll;
        int hit_pct;
        logic [OP_W-1:0] op;

        key_pool[0] = VAL_MIN;
        key_pool[1] = VAL_MAX;
        key_pool[2] = '0;
        key_pool[3] = VAL_NEG1;
        key_pool[4] = 32'd1;
        for (int j = 5; j < POOL_SIZE; j++)
            key_pool[j] = $urandom();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Everything on an empty stack, unused codes included
        send_item(OP_SEARCH, VAL_MAX, '0);
        send_item(OP_MODIFY, VAL_MIN, VAL_MAX);
        send_item(OP_REMOVE, '0, '0);
        send_item(OP_LIST, VAL_NEG1, VAL_NEG1);
        send_item(OP_SPARE_FIRST, VAL_NEG1, VAL_NEG1);
        send_item(OP_SPARE_FIRST + 3'd1, VAL_MIN, VAL_MAX);
        send_item(OP_SPARE_LAST, '0, '0);

        // Extremes, with a duplicate
        send_item(OP_PUSH, VAL_MIN, '0);
        send_item(OP_PUSH, VAL_MAX, '0);
        send_item(OP_PUSH, '0, '0);
        send_item(OP_PUSH, VAL_NEG1, '0);
        send_item(OP_PUSH, VAL_MAX, '0);

        // Multiple matches and misses
        send_item(OP_SEARCH, VAL_MAX, '0);
        send_item(OP_SEARCH, 32'h1234_5678, '0);
        send_item(OP_MODIFY, VAL_MAX, VAL_MIN);
        send_item(OP_MODIFY, 32'h0000_0007, 32'd1);
        send_item(OP_LIST, '0, '0);

        // Remove from the middle, a miss, then from the top
        send_item(OP_REMOVE, '0, '0);
        send_item(OP_REMOVE, 32'h0bad_cafe, '0);
        send_item(OP_LIST, '0, '0);
        send_item(OP_REMOVE, VAL_NEG1, '0);
        send_item(OP_REMOVE, VAL_MIN, '0);
        send_item(OP_LIST, '0, '0);

        // Random rounds: fill to full and beyond, mixed traffic, then drain
        for (int r = 0; r < 3; r++) begin
            no_idle = (r == 1);
            key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom();
            key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom();
            for (int k = 0; k < 50; k++) begin
                roll    = $urandom_range(0, 99);
                hit_pct = 60;
                if (k < 20) begin
                    if (roll < 80)      op = OP_PUSH;
                    else if (roll < 86) op = OP_SEARCH;
                    else if (roll < 92) op = OP_LIST;
                    else if (roll < 97) op = OP_MODIFY;
                    else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end
                else if (k < 36) begin
                    if (roll < 25)      op = OP_PUSH;
                    else if (roll < 45) op = OP_SEARCH;
                    else if (roll < 65) op = OP_MODIFY;
                    else if (roll < 80) op = OP_REMOVE;
                    else if (roll < 95) op = OP_LIST;
                    else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end
                else begin
                    hit_pct = 90;
                    if (roll < 75)      op = OP_REMOVE;
                    else if (roll < 85) op = OP_LIST;
                    else if (roll < 95) op = OP_SEARCH;
                    else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end
                send_item(op, pick_value(hit_pct), pick_value(hit_pct));
            end
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        // Drain outstanding results
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d stack operations and checked %0d results", n_items, n_results);
        $display("Covered empty and full stacks, extreme values, unused op codes and random rounds");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/vss_pkg.sv
rtl/vss_datapath.sv
rtl/vss_ctrl.sv
rtl/value_search_stack.sv
rtl/vss_checker.sv
dv/value_search_checker.sv
dv/tb_top.sv
